@@ rtl/spc_pkg.sv @@
// spc_pkg: shared types and constants for the SAT polygon collision unit.
// Used by sat_polygon_collision_unit, spc_div and spc_isqrt. No dependencies.
package spc_pkg;

	localparam int MAX_VERTICES = 16;
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int ADDR_W       = VIDX_W + 1;
	localparam int COORD_W      = 32;
	localparam int NRM_W        = 32;
	localparam int NRM_FRAC     = 30;
	localparam int SUM_W        = COORD_W + CNT_W;
	localparam int PROJ_W       = 64;
	localparam int LEN_W        = NRM_FRAC + 1;
	localparam int SQ_W         = 64;
	localparam int DIV_NUM_W    = 2 * NRM_FRAC + 1;
	localparam int DIV_DEN_W    = LEN_W;
	localparam int DIV_CNT_W    = $clog2(DIV_NUM_W);

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FEW  = 2'd1,
		ST_MANY = 2'd2
	} status_t;

	typedef struct packed {
		logic                      which_polygon;
		logic signed [COORD_W-1:0] vertex_x;
		logic signed [COORD_W-1:0] vertex_y;
		logic                      last_vertex;
	} vtx_req_t;

	typedef struct packed {
		logic                    hit;
		logic [30:0]             overlap_depth;
		logic signed [NRM_W-1:0] normal_x;
		logic signed [NRM_W-1:0] normal_y;
		status_t                 status;
	} res_rsp_t;

endpackage

@@ rtl/sat_polygon_collision_unit.sv @@
// sat_polygon_collision_unit: 2D convex polygon overlap test by separating axes.
// Depends on spc_pkg, spc_div, spc_isqrt.
// Vertex requests: one per cycle while idle; none taken from B's last vertex until the result.
// Per edge, a test after B's last vertex runs up to 29 normalizing shift steps, two divider
// waits, the square root and a projection sweep over both polygons (a zero-length edge skips
// these); a hit adds four centroid divisions.
// Reset clears counts, flags and control; vertex memory contents are not cleared.
module sat_polygon_collision_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vtx_valid,
	output logic              vtx_ready,
	input  spc_pkg::vtx_req_t vtx,
	output logic              res_valid,
	input  logic              res_ready,
	output spc_pkg::res_rsp_t res
);

	typedef enum logic [4:0] {
		S_IDLE, S_CHECK, S_EDGE_A, S_EDGE_B, S_EDGE_C, S_NORM, S_SQ, S_SUM, S_SQRT,
		S_DIVA0, S_DIVA1, S_DIVB0, S_DIVB1, S_PROJ, S_CMP, S_NEXT,
		S_CDIV0, S_CDIV1, S_DOT, S_FLIP, S_DONE
	} state_t;

	localparam int VW = 2 * spc_pkg::COORD_W;
	localparam int CW = spc_pkg::COORD_W;
	localparam int DP_W = CW + 2 + spc_pkg::NRM_W;

	state_t state_q;

	logic [VW-1:0] vmem [0:2*spc_pkg::MAX_VERTICES-1];
	logic [VW-1:0] rd_data_q;
	logic [spc_pkg::ADDR_W-1:0] rd_addr;
	logic [spc_pkg::ADDR_W-1:0] wr_addr;
	logic mem_we;

	logic [spc_pkg::CNT_W-1:0] cnt_a_q, cnt_b_q, sel_cnt, n_cur;
	logic ovf_q;
	logic signed [spc_pkg::SUM_W-1:0] sum_ax_q, sum_ay_q, sum_bx_q, sum_by_q;

	logic vtx_fire, sel_full;
	logic pass_q;
	logic [spc_pkg::VIDX_W-1:0] i_q, j_idx;
	logic last_edge;
	logic [VW-1:0] vi_q;

	logic signed [CW:0] ex, ey;
	logic [CW:0] ax, ay, m;
	logic [CW:0] a_q, b_q;
	logic ex_neg_q, ey_pos_q;

	logic [2*spc_pkg::NRM_FRAC-1:0] sqa_s1, sqb_s1;
	logic [spc_pkg::LEN_W-1:0] len_q;
	logic signed [spc_pkg::NRM_W-1:0] nx_q, ny_q, qv;
	logic signed [spc_pkg::NRM_W-1:0] bnx_q, bny_q;

	logic [spc_pkg::CNT_W:0] k_q, total;
	logic [spc_pkg::CNT_W:0] k_off;
	logic issue;
	logic [spc_pkg::ADDR_W-1:0] proj_addr;
	logic pv_s1, pb_s1, pf_s1, pv_s2, pb_s2, pf_s2;
	logic signed [spc_pkg::PROJ_W-1:0] px_s2, py_s2, p;
	logic signed [CW-1:0] rd_x, rd_y;
	logic signed [spc_pkg::PROJ_W-1:0] min_a_q, max_a_q, min_b_q, max_b_q;
	logic signed [spc_pkg::PROJ_W-1:0] d1, d2, d, best_q;
	logic tested_q, hit_q;
	spc_pkg::status_t status_q;

	logic [1:0] cidx_q;
	logic signed [spc_pkg::SUM_W-1:0] csum;
	logic [spc_pkg::SUM_W-1:0] cabs;
	logic cneg_q;
	logic signed [CW:0] cq;
	logic signed [CW:0] cax_q, cay_q, cbx_q, cby_q;
	logic signed [CW+1:0] dx, dy;
	logic signed [DP_W-1:0] dpx_s1, dpy_s1;
	logic signed [DP_W:0] dsum;

	logic [spc_pkg::PROJ_W-1:0] rnd;
	logic [spc_pkg::PROJ_W-1-spc_pkg::NRM_FRAC:0] dq;
	logic [30:0] depth;

	logic div_start, div_done;
	logic [spc_pkg::DIV_NUM_W-1:0] div_num, div_quo;
	logic [spc_pkg::DIV_DEN_W-1:0] div_den;
	logic sq_start, sq_done;
	logic [spc_pkg::SQ_W-1:0] sq_rad, sq_root;

	logic res_valid_q;
	spc_pkg::res_rsp_t res_q;

	spc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	spc_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.rad    (sq_rad),
		.done   (sq_done),
		.root   (sq_root)
	);

	// Writes happen only in S_IDLE and reads only during a test, so no
	// same-entry overlap is possible.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			vmem[wr_addr] <= {vtx.vertex_x, vtx.vertex_y};
		end
		rd_data_q <= vmem[rd_addr];
	end

	always_comb begin
		vtx_ready = (state_q == S_IDLE);
		vtx_fire  = vtx_valid && vtx_ready;
		sel_cnt   = vtx.which_polygon ? cnt_b_q : cnt_a_q;
		sel_full  = (sel_cnt == spc_pkg::CNT_W'(spc_pkg::MAX_VERTICES));
		mem_we    = vtx_fire && !sel_full;
		wr_addr   = {vtx.which_polygon, sel_cnt[spc_pkg::VIDX_W-1:0]};

		n_cur     = pass_q ? cnt_b_q : cnt_a_q;
		last_edge = (spc_pkg::CNT_W'(i_q) + 1'b1) == n_cur;
		j_idx     = last_edge ? '0 : i_q + 1'b1;

		rd_x = rd_data_q[VW-1:CW];
		rd_y = rd_data_q[CW-1:0];
		ex = (CW+1)'(rd_x) - (CW+1)'($signed(vi_q[VW-1:CW]));
		ey = (CW+1)'(rd_y) - (CW+1)'($signed(vi_q[CW-1:0]));
		ax = ex[CW] ? $unsigned(-ex) : $unsigned(ex);
		ay = ey[CW] ? $unsigned(-ey) : $unsigned(ey);
		m  = (a_q > b_q) ? a_q : b_q;

		total = (spc_pkg::CNT_W+1)'(cnt_a_q) + (spc_pkg::CNT_W+1)'(cnt_b_q);
		issue = k_q < total;
		k_off = k_q - (spc_pkg::CNT_W+1)'(cnt_a_q);
		proj_addr = (k_q < (spc_pkg::CNT_W+1)'(cnt_a_q)) ?
			{1'b0, k_q[spc_pkg::VIDX_W-1:0]} : {1'b1, k_off[spc_pkg::VIDX_W-1:0]};
		p = px_s2 + py_s2;

		d1 = max_b_q - min_a_q;
		d2 = max_a_q - min_b_q;
		d  = (d2 < d1) ? d2 : d1;

		case (state_q)
			S_EDGE_A: rd_addr = {pass_q, i_q};
			S_EDGE_B: rd_addr = {pass_q, j_idx};
			S_PROJ:   rd_addr = proj_addr;
			default:  rd_addr = '0;
		endcase

		qv = $signed(spc_pkg::NRM_W'(div_quo[spc_pkg::NRM_FRAC:0]));

		case (cidx_q)
			2'd0:    csum = sum_ax_q;
			2'd1:    csum = sum_ay_q;
			2'd2:    csum = sum_bx_q;
			default: csum = sum_by_q;
		endcase
		cabs = csum[spc_pkg::SUM_W-1] ? $unsigned(-csum) : $unsigned(csum);
		cq   = $signed({1'b0, div_quo[CW-1:0]});

		div_start = (state_q == S_DIVA0) || (state_q == S_DIVB0) || (state_q == S_CDIV0);
		case (state_q)
			S_DIVA0: begin
				div_num = spc_pkg::DIV_NUM_W'({a_q[spc_pkg::NRM_FRAC-1:0],
					{spc_pkg::NRM_FRAC{1'b0}}}) +
					spc_pkg::DIV_NUM_W'(len_q[spc_pkg::LEN_W-1:1]);
				div_den = len_q;
			end
			S_DIVB0: begin
				div_num = spc_pkg::DIV_NUM_W'({b_q[spc_pkg::NRM_FRAC-1:0],
					{spc_pkg::NRM_FRAC{1'b0}}}) +
					spc_pkg::DIV_NUM_W'(len_q[spc_pkg::LEN_W-1:1]);
				div_den = len_q;
			end
			default: begin
				div_num = spc_pkg::DIV_NUM_W'(cabs);
				div_den = spc_pkg::DIV_DEN_W'(cidx_q[1] ? cnt_b_q : cnt_a_q);
			end
		endcase

		sq_start = (state_q == S_SUM);
		sq_rad   = spc_pkg::SQ_W'(sqa_s1) + spc_pkg::SQ_W'(sqb_s1);

		dx   = (CW+2)'(cbx_q) - (CW+2)'(cax_q);
		dy   = (CW+2)'(cby_q) - (CW+2)'(cay_q);
		dsum = (DP_W+1)'(dpx_s1) + (DP_W+1)'(dpy_s1);

		rnd   = $unsigned(best_q) + (spc_pkg::PROJ_W'(1) << (spc_pkg::NRM_FRAC - 1));
		dq    = rnd[spc_pkg::PROJ_W-1:spc_pkg::NRM_FRAC];
		depth = (dq[spc_pkg::PROJ_W-1-spc_pkg::NRM_FRAC:31] != '0) ? '1 : dq[30:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_a_q     <= '0;
			cnt_b_q     <= '0;
			ovf_q       <= 1'b0;
			sum_ax_q    <= '0;
			sum_ay_q    <= '0;
			sum_bx_q    <= '0;
			sum_by_q    <= '0;
			pass_q      <= 1'b0;
			i_q         <= '0;
			vi_q        <= '0;
			a_q         <= '0;
			b_q         <= '0;
			ex_neg_q    <= 1'b0;
			ey_pos_q    <= 1'b0;
			sqa_s1      <= '0;
			sqb_s1      <= '0;
			len_q       <= '0;
			nx_q        <= '0;
			ny_q        <= '0;
			bnx_q       <= '0;
			bny_q       <= '0;
			k_q         <= '0;
			pv_s1       <= 1'b0;
			pb_s1       <= 1'b0;
			pf_s1       <= 1'b0;
			pv_s2       <= 1'b0;
			pb_s2       <= 1'b0;
			pf_s2       <= 1'b0;
			px_s2       <= '0;
			py_s2       <= '0;
			min_a_q     <= '0;
			max_a_q     <= '0;
			min_b_q     <= '0;
			max_b_q     <= '0;
			best_q      <= '0;
			tested_q    <= 1'b0;
			hit_q       <= 1'b0;
			status_q    <= spc_pkg::ST_OK;
			cidx_q      <= '0;
			cneg_q      <= 1'b0;
			cax_q       <= '0;
			cay_q       <= '0;
			cbx_q       <= '0;
			cby_q       <= '0;
			dpx_s1      <= '0;
			dpy_s1      <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_valid_q && res_ready && state_q != S_DONE) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (vtx_fire) begin
						if (sel_full) begin
							ovf_q <= 1'b1;
						end else if (vtx.which_polygon) begin
							cnt_b_q  <= cnt_b_q + 1'b1;
							sum_bx_q <= sum_bx_q + spc_pkg::SUM_W'(vtx.vertex_x);
							sum_by_q <= sum_by_q + spc_pkg::SUM_W'(vtx.vertex_y);
						end else begin
							cnt_a_q  <= cnt_a_q + 1'b1;
							sum_ax_q <= sum_ax_q + spc_pkg::SUM_W'(vtx.vertex_x);
							sum_ay_q <= sum_ay_q + spc_pkg::SUM_W'(vtx.vertex_y);
						end
						if (vtx.which_polygon && vtx.last_vertex) begin
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					hit_q    <= 1'b0;
					tested_q <= 1'b0;
					pass_q   <= 1'b0;
					i_q      <= '0;
					if (ovf_q) begin
						status_q <= spc_pkg::ST_MANY;
						state_q  <= S_DONE;
					end else if (cnt_a_q < spc_pkg::CNT_W'(3) || cnt_b_q < spc_pkg::CNT_W'(3)) begin
						status_q <= spc_pkg::ST_FEW;
						state_q  <= S_DONE;
					end else begin
						status_q <= spc_pkg::ST_OK;
						state_q  <= S_EDGE_A;
					end
				end
				S_EDGE_A: state_q <= S_EDGE_B;
				S_EDGE_B: begin
					vi_q    <= rd_data_q;
					state_q <= S_EDGE_C;
				end
				S_EDGE_C: begin
					a_q      <= ax;
					b_q      <= ay;
					ex_neg_q <= ex[CW];
					ey_pos_q <= !ey[CW] && (ey != '0);
					state_q  <= (ax == '0 && ay == '0) ? S_NEXT : S_NORM;
				end
				S_NORM: begin
					if (m[CW:spc_pkg::NRM_FRAC] != '0) begin
						a_q <= a_q >> 1;
						b_q <= b_q >> 1;
					end else if (!m[spc_pkg::NRM_FRAC-1]) begin
						a_q <= {a_q[CW-1:0], 1'b0};
						b_q <= {b_q[CW-1:0], 1'b0};
					end else begin
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					sqa_s1  <= a_q[spc_pkg::NRM_FRAC-1:0] * a_q[spc_pkg::NRM_FRAC-1:0];
					sqb_s1  <= b_q[spc_pkg::NRM_FRAC-1:0] * b_q[spc_pkg::NRM_FRAC-1:0];
					state_q <= S_SUM;
				end
				S_SUM: state_q <= S_SQRT;
				S_SQRT: begin
					if (sq_done) begin
						len_q   <= sq_root[spc_pkg::LEN_W-1:0];
						state_q <= S_DIVA0;
					end
				end
				S_DIVA0: state_q <= S_DIVA1;
				S_DIVA1: begin
					if (div_done) begin
						ny_q    <= ex_neg_q ? -qv : qv;
						state_q <= S_DIVB0;
					end
				end
				S_DIVB0: state_q <= S_DIVB1;
				S_DIVB1: begin
					if (div_done) begin
						nx_q    <= ey_pos_q ? -qv : qv;
						k_q     <= '0;
						pv_s1   <= 1'b0;
						pv_s2   <= 1'b0;
						state_q <= S_PROJ;
					end
				end
				S_PROJ: begin
					pv_s1 <= issue;
					pb_s1 <= !(k_q < (spc_pkg::CNT_W+1)'(cnt_a_q));
					pf_s1 <= (k_q == '0) || (k_q == (spc_pkg::CNT_W+1)'(cnt_a_q));
					if (issue) begin
						k_q <= k_q + 1'b1;
					end
					pv_s2 <= pv_s1;
					pb_s2 <= pb_s1;
					pf_s2 <= pf_s1;
					px_s2 <= rd_x * nx_q;
					py_s2 <= rd_y * ny_q;
					if (pv_s2) begin
						if (pb_s2) begin
							if (pf_s2 || p < min_b_q) min_b_q <= p;
							if (pf_s2 || p > max_b_q) max_b_q <= p;
						end else begin
							if (pf_s2 || p < min_a_q) min_a_q <= p;
							if (pf_s2 || p > max_a_q) max_a_q <= p;
						end
					end
					if (!issue && !pv_s1 && !pv_s2) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (min_a_q >= max_b_q || min_b_q >= max_a_q) begin
						hit_q   <= 1'b0;
						state_q <= S_DONE;
					end else begin
						if (!tested_q || d < best_q) begin
							best_q <= d;
							bnx_q  <= nx_q;
							bny_q  <= ny_q;
						end
						tested_q <= 1'b1;
						state_q  <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (last_edge) begin
						i_q <= '0;
						if (!pass_q) begin
							pass_q  <= 1'b1;
							state_q <= S_EDGE_A;
						end else if (tested_q) begin
							cidx_q  <= '0;
							state_q <= S_CDIV0;
						end else begin
							hit_q   <= 1'b0;
							state_q <= S_DONE;
						end
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_EDGE_A;
					end
				end
				S_CDIV0: begin
					cneg_q  <= csum[spc_pkg::SUM_W-1];
					state_q <= S_CDIV1;
				end
				S_CDIV1: begin
					if (div_done) begin
						case (cidx_q)
							2'd0:    cax_q <= cneg_q ? -cq : cq;
							2'd1:    cay_q <= cneg_q ? -cq : cq;
							2'd2:    cbx_q <= cneg_q ? -cq : cq;
							default: cby_q <= cneg_q ? -cq : cq;
						endcase
						cidx_q  <= cidx_q + 1'b1;
						state_q <= (cidx_q == 2'd3) ? S_DOT : S_CDIV0;
					end
				end
				S_DOT: begin
					dpx_s1  <= dx * bnx_q;
					dpy_s1  <= dy * bny_q;
					state_q <= S_FLIP;
				end
				S_FLIP: begin
					if (dsum[DP_W]) begin
						bnx_q <= -bnx_q;
						bny_q <= -bny_q;
					end
					hit_q   <= 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!res_valid_q || res_ready) begin
						res_valid_q         <= 1'b1;
						res_q.hit           <= hit_q;
						res_q.overlap_depth <= hit_q ? depth : '0;
						res_q.normal_x      <= hit_q ? bnx_q : '0;
						res_q.normal_y      <= hit_q ? bny_q : '0;
						res_q.status        <= status_q;
						cnt_a_q             <= '0;
						cnt_b_q             <= '0;
						ovf_q               <= 1'b0;
						sum_ax_q            <= '0;
						sum_ay_q            <= '0;
						sum_bx_q            <= '0;
						sum_by_q            <= '0;
						state_q             <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_a_q <= spc_pkg::CNT_W'(spc_pkg::MAX_VERTICES) &&
		cnt_b_q <= spc_pkg::CNT_W'(spc_pkg::MAX_VERTICES))
		else $error("vertex count beyond memory depth");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.hit |->
		res_q.overlap_depth == '0 && res_q.normal_x == '0 && res_q.normal_y == '0)
		else $error("miss result carries nonzero depth or normal");

	a_err_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.status != spc_pkg::ST_OK |-> !res_q.hit)
		else $error("error status with hit set");

	a_proj_counts: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PROJ |-> cnt_a_q >= spc_pkg::CNT_W'(3) &&
		cnt_b_q >= spc_pkg::CNT_W'(3) && !ovf_q)
		else $error("projection sweep with invalid polygon");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIVA1 || state_q == S_DIVB1 || state_q == S_CDIV1)
		else $error("divider finished outside a wait state");

endmodule

@@ rtl/spc_div.sv @@
// spc_div: unsigned restoring divider, one quotient bit per cycle.
// Depends on spc_pkg for widths.
module spc_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [spc_pkg::DIV_NUM_W-1:0]   num,
	input  logic [spc_pkg::DIV_DEN_W-1:0]   den,
	output logic                            done,
	output logic [spc_pkg::DIV_NUM_W-1:0]   quo
);

	logic [spc_pkg::DIV_NUM_W-1:0] num_q;
	logic [spc_pkg::DIV_DEN_W-1:0] rem_q;
	logic [spc_pkg::DIV_DEN_W-1:0] den_q;
	logic [spc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [spc_pkg::DIV_DEN_W:0]   trial;
	logic [spc_pkg::DIV_DEN_W:0]   diff;
	logic                          ge;

	always_comb begin
		trial = {rem_q, num_q[spc_pkg::DIV_NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == '0);
			if (start) begin
				num_q  <= num;
				rem_q  <= '0;
				den_q  <= den;
				cnt_q  <= spc_pkg::DIV_CNT_W'(spc_pkg::DIV_NUM_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? diff[spc_pkg::DIV_DEN_W-1:0] : trial[spc_pkg::DIV_DEN_W-1:0];
				num_q <= {num_q[spc_pkg::DIV_NUM_W-2:0], ge};
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = num_q;

endmodule

@@ rtl/spc_isqrt.sv @@
// spc_isqrt: integer square root, one result bit per cycle.
// Depends on spc_pkg for widths.
module spc_isqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [spc_pkg::SQ_W-1:0] rad,
	output logic                     done,
	output logic [spc_pkg::SQ_W-1:0] root
);

	logic [spc_pkg::SQ_W-1:0] v_q;
	logic [spc_pkg::SQ_W-1:0] res_q;
	logic [spc_pkg::SQ_W-1:0] bit_q;
	logic                     busy_q;
	logic                     done_q;
	logic [spc_pkg::SQ_W-1:0] cand;

	assign cand = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q    <= '0;
			res_q  <= '0;
			bit_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && busy_q && bit_q[0];
			if (start) begin
				v_q    <= rad;
				res_q  <= '0;
				bit_q  <= {2'b01, {(spc_pkg::SQ_W-2){1'b0}}};
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (v_q >= cand) begin
					v_q   <= v_q - cand;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done = done_q;
	assign root = res_q;

endmodule
